FILE: rtl/gcdist_pkg.sv
// shared constants, types and helper functions for the great-circle distance block
// fixed-point formats, cordic arctangent table and pipeline latencies
// no dependencies
package gcdist_pkg;

  // angle fraction bits and cordic steps
  localparam int F          = 30;
  localparam int ITER       = 32;

  localparam logic [63:0] PI_Q62   = 64'hC90FDAA22168C235;
  localparam logic [63:0] GAIN_Q62 = 64'd2800459870029452954;

  // Q62 constant rounded half up to F fraction bits
  function automatic logic [63:0] q62_to_f(input logic [63:0] c);
    return (c + (64'd1 << (61 - F))) >> (62 - F);
  endfunction

  localparam logic [63:0] PI_F   = q62_to_f(PI_Q62);
  localparam logic [63:0] HALF_F = q62_to_f(PI_Q62 >> 1);
  localparam logic [63:0] GAIN_F = q62_to_f(GAIN_Q62);

  // hundredths of a minute in half a turn
  localparam logic [63:0] HMIN_HALF_TURN = 64'd1080000;
  // pi_f split over the half-turn divisor: pi_f = DIV_Q * 1080000 + DIV_R
  localparam logic [63:0] DIV_Q = PI_F / HMIN_HALF_TURN;
  localparam logic [63:0] DIV_R = PI_F % HMIN_HALF_TURN;

  // widths
  localparam int HW    = 21;   // deg * 6000 + hmin
  localparam int TW    = 40;   // remainder numerator h * DIV_R + half divisor
  localparam int BW    = 33;   // h * DIV_Q
  localparam int QB    = 20;   // quotient bits of the half-turn division
  localparam int AW    = 36;   // angles, dot product, vectoring x/y/z
  localparam int CW    = 34;   // sin, cos, vector parts
  localparam int MW    = 32;   // product operand magnitudes
  localparam int RW    = 32;   // square root
  localparam int REM_W = 36;   // square root remainder
  localparam int ZW    = 32;   // central angle
  localparam int RADW  = 13;
  localparam int RADMW = 23;
  localparam int DISTW = 25;
  localparam int ADDRW = 3;
  localparam int SQRT_STEPS = 32;

  // half-turn divisor = 2^DSH_B * DIV_ODD; the odd part is divided by a
  // reciprocal estimate that is at most one short, then corrected once
  localparam int          DSH_B   = 6;
  localparam logic [63:0] DIV_ODD = HMIN_HALF_TURN >> DSH_B;
  localparam int          NW      = TW - DSH_B;   // numerator after the shift
  localparam int          RCP_SH  = NW;
  localparam int          RCPW    = 20;
  localparam logic [RCPW-1:0] RCP = RCPW'((64'd1 << RCP_SH) / DIV_ODD);

  localparam int SC_LAT   = ITER + 9;
  localparam int ACOS_LAT = SQRT_STEPS + ITER + 2;
  localparam int TOT      = SC_LAT + 5 + ACOS_LAT + 2;

  localparam logic             REG_RADIUS   = 1'b0;
  localparam logic [RADW-1:0]  RADIUS_RESET = 13'd6370;
  localparam logic [DISTW-1:0] DIST_MAX     = '1;

  typedef logic signed [AW-1:0] angle_t;
  typedef logic signed [CW-1:0] trig_t;

  // atan(2^-i) in Q62 by its power series
  function automatic logic [63:0] atn_q62(input int i);
    logic [63:0] acc;
    logic [63:0] term;
    int e;
    acc = '0;
    if (i == 0) begin
      acc = PI_Q62 >> 2;
    end else begin
      for (int k = 0; k < 32; k++) begin
        e = i * (2 * k + 1);
        if (e <= 62) begin
          term = (64'd1 << (62 - e)) / 64'(2 * k + 1);
          if (k % 2 == 1) acc = acc - term;
          else acc = acc + term;
        end
      end
    end
    return acc;
  endfunction

  function automatic logic [63:0] atn_f(input int i);
    return q62_to_f(atn_q62(i));
  endfunction

  function automatic logic [MW-1:0] mag(input trig_t v);
    trig_t a;
    a = (v < 0) ? -v : v;
    return a[MW-1:0];
  endfunction

  // product rounded half away from zero back to F fraction bits
  function automatic angle_t round_mul(input logic [2*MW-1:0] p, input logic neg);
    logic [2*MW-1:0] r;
    angle_t s;
    r = (p + (64'd1 << (F - 1))) >> F;
    s = $signed(r[AW-1:0]);
    return neg ? -s : s;
  endfunction

endpackage

FILE: rtl/great_circle_distance.sv
// top level of the great-circle distance block: ports, radius register, dot product,
// scaling and output register; uses gcdist_pkg, gcdist_sincos and gcdist_acos
// assertions at the end
//
// Takes two positions (degrees, hundredths of a minute, hemisphere flags) and returns
// the great-circle distance in metres as radius * acos(p . q), with a flag when the
// computed dot product fell outside unit range and was clamped. The datapath is one
// fixed pipeline of 114 register stages: four cordic rotators for the sines and
// cosines, the dot product, a bit-a-stage square root and a cordic vectoring unit.
// One item is accepted every cycle while coord_stall is low; each result passes the
// pipeline, then the output register. When a result waits at the output the pipeline
// keeps moving as long as its last stage is empty, so coord_stall only rises once a
// result is held at the output and another is ready behind it. The radius register
// sits at byte address 0 of the APB-style port and should be written only while the
// block is empty.
module great_circle_distance (
  input  logic        clk,
  input  logic        rst,
  // configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [gcdist_pkg::ADDRW-1:0] paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // input items
  input  logic        coord_valid,
  output logic        coord_stall,
  input  logic [6:0]  first_lat_degrees,
  input  logic [12:0] first_lat_minutes,
  input  logic        first_lat_south,
  input  logic [7:0]  first_lon_degrees,
  input  logic [12:0] first_lon_minutes,
  input  logic        first_lon_west,
  input  logic [6:0]  second_lat_degrees,
  input  logic [12:0] second_lat_minutes,
  input  logic        second_lat_south,
  input  logic [7:0]  second_lon_degrees,
  input  logic [12:0] second_lon_minutes,
  input  logic        second_lon_west,
  // result items
  output logic        dist_valid,
  input  logic        dist_stall,
  output logic [24:0] distance_milli_km,
  output logic        dot_clamped
);

  localparam int AW       = gcdist_pkg::AW;
  localparam int MW       = gcdist_pkg::MW;
  localparam int ZW       = gcdist_pkg::ZW;
  localparam int RADW     = gcdist_pkg::RADW;
  localparam int RADMW    = gcdist_pkg::RADMW;
  localparam int DISTW    = gcdist_pkg::DISTW;
  localparam int TOT      = gcdist_pkg::TOT;
  localparam int ACOS_LAT = gcdist_pkg::ACOS_LAT;
  localparam int PW       = ZW + RADMW;

  localparam gcdist_pkg::angle_t ONE_S = AW'(64'd1 << gcdist_pkg::F);

  // radius register, with radius * 1000 kept alongside
  logic [RADW-1:0]  radius;
  logic [RADMW-1:0] radm;
  logic             cfg_wr;

  // pipeline control
  logic             en;
  logic [TOT-1:0]   vld;

  // rotator outputs
  gcdist_pkg::trig_t cl1, sl1, co1, so1, cl2, sl2, co2, so2;

  // vector stage
  logic [2*MW-1:0]   v1a, v1b, v2a, v2b;
  logic              n1a, n1b, n2a, n2b;
  gcdist_pkg::trig_t s1z, s2z;
  gcdist_pkg::angle_t p0, p1, p2, q0, q1, q2;

  // dot stage
  logic [2*MW-1:0]   t0, t1, t2;
  logic              tn0, tn1, tn2;
  gcdist_pkg::angle_t u0, u1, u2;
  gcdist_pkg::angle_t dsum;
  gcdist_pkg::angle_t dcl;
  logic [ACOS_LAT+2:0] csh;

  // scaling
  gcdist_pkg::angle_t zang;
  logic [ZW-1:0]      zpos;
  logic [PW-1:0]      prod;
  logic [PW-1:0]      prnd;
  logic [DISTW-1:0]   dist_o;

  // ---------------------------------------------------------------------------
  // configuration port
  // ---------------------------------------------------------------------------
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      radius <= gcdist_pkg::RADIUS_RESET;
      radm   <= RADMW'(gcdist_pkg::RADIUS_RESET) * RADMW'(1000);
    end else if (cfg_wr && paddr[2] == gcdist_pkg::REG_RADIUS) begin
      radius <= pwdata[RADW-1:0];
      radm   <= RADMW'(pwdata[RADW-1:0]) * RADMW'(1000);
    end
  end

  assign prdata = (paddr[2] == gcdist_pkg::REG_RADIUS) ? 32'(radius) : '0;

  // ---------------------------------------------------------------------------
  // pipeline control: everything moves together unless a result is held at the
  // output and the last stage has another one ready
  // ---------------------------------------------------------------------------
  assign en          = !dist_valid || !dist_stall || !vld[TOT-1];
  assign coord_stall = !en;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[TOT-2:0], coord_valid};
    end
  end

  // ---------------------------------------------------------------------------
  // sin and cos of the four angles
  // ---------------------------------------------------------------------------
  gcdist_sincos u_lat1 (
    .clk(clk), .en(en), .deg(8'(first_lat_degrees)), .hmin(first_lat_minutes),
    .neg(first_lat_south), .cos_v(cl1), .sin_v(sl1)
  );
  gcdist_sincos u_lon1 (
    .clk(clk), .en(en), .deg(first_lon_degrees), .hmin(first_lon_minutes),
    .neg(first_lon_west), .cos_v(co1), .sin_v(so1)
  );
  gcdist_sincos u_lat2 (
    .clk(clk), .en(en), .deg(8'(second_lat_degrees)), .hmin(second_lat_minutes),
    .neg(second_lat_south), .cos_v(cl2), .sin_v(sl2)
  );
  gcdist_sincos u_lon2 (
    .clk(clk), .en(en), .deg(second_lon_degrees), .hmin(second_lon_minutes),
    .neg(second_lon_west), .cos_v(co2), .sin_v(so2)
  );

  // ---------------------------------------------------------------------------
  // unit vectors (cos lat cos lon, cos lat sin lon, sin lat)
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (en) begin
      v1a <= (2*MW)'(gcdist_pkg::mag(cl1)) * (2*MW)'(gcdist_pkg::mag(co1));
      v1b <= (2*MW)'(gcdist_pkg::mag(cl1)) * (2*MW)'(gcdist_pkg::mag(so1));
      v2a <= (2*MW)'(gcdist_pkg::mag(cl2)) * (2*MW)'(gcdist_pkg::mag(co2));
      v2b <= (2*MW)'(gcdist_pkg::mag(cl2)) * (2*MW)'(gcdist_pkg::mag(so2));
      n1a <= (cl1 < 0) != (co1 < 0);
      n1b <= (cl1 < 0) != (so1 < 0);
      n2a <= (cl2 < 0) != (co2 < 0);
      n2b <= (cl2 < 0) != (so2 < 0);
      s1z <= sl1;
      s2z <= sl2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p0 <= gcdist_pkg::round_mul(v1a, n1a);
      p1 <= gcdist_pkg::round_mul(v1b, n1b);
      p2 <= AW'(s1z);
      q0 <= gcdist_pkg::round_mul(v2a, n2a);
      q1 <= gcdist_pkg::round_mul(v2b, n2b);
      q2 <= AW'(s2z);
    end
  end

  // ---------------------------------------------------------------------------
  // dot product, three products then rounding then the sum and the clamp
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (en) begin
      t0  <= (2*MW)'(gcdist_pkg::mag(gcdist_pkg::CW'(p0))) *
             (2*MW)'(gcdist_pkg::mag(gcdist_pkg::CW'(q0)));
      t1  <= (2*MW)'(gcdist_pkg::mag(gcdist_pkg::CW'(p1))) *
             (2*MW)'(gcdist_pkg::mag(gcdist_pkg::CW'(q1)));
      t2  <= (2*MW)'(gcdist_pkg::mag(gcdist_pkg::CW'(p2))) *
             (2*MW)'(gcdist_pkg::mag(gcdist_pkg::CW'(q2)));
      tn0 <= (p0 < 0) != (q0 < 0);
      tn1 <= (p1 < 0) != (q1 < 0);
      tn2 <= (p2 < 0) != (q2 < 0);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      u0 <= gcdist_pkg::round_mul(t0, tn0);
      u1 <= gcdist_pkg::round_mul(t1, tn1);
      u2 <= gcdist_pkg::round_mul(t2, tn2);
    end
  end

  assign dsum = u0 + u1 + u2;

  // clamp flag then rides a delay line next to the acos pipeline
  always_ff @(posedge clk) begin
    if (en) begin
      if (dsum > ONE_S) begin
        dcl    <= ONE_S;
        csh[0] <= 1'b1;
      end else if (dsum < -ONE_S) begin
        dcl    <= -ONE_S;
        csh[0] <= 1'b1;
      end else begin
        dcl    <= dsum;
        csh[0] <= 1'b0;
      end
      csh[ACOS_LAT+2:1] <= csh[ACOS_LAT+1:0];
    end
  end

  gcdist_acos u_acos (
    .clk(clk), .en(en), .d(dcl), .z(zang)
  );

  // ---------------------------------------------------------------------------
  // scale by the radius, round to metres, saturate
  // ---------------------------------------------------------------------------
  assign zpos = (zang < 0) ? '0 : zang[ZW-1:0];

  always_ff @(posedge clk) begin
    if (en) begin
      prod <= PW'(zpos) * PW'(radm);
    end
  end

  assign prnd = (prod + PW'(64'd1 << (gcdist_pkg::F - 1))) >> gcdist_pkg::F;

  always_ff @(posedge clk) begin
    if (en) begin
      dist_o <= (prnd > PW'(gcdist_pkg::DIST_MAX)) ? gcdist_pkg::DIST_MAX : prnd[DISTW-1:0];
    end
  end

  // ---------------------------------------------------------------------------
  // output register
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      dist_valid <= 1'b0;
    end else if (!dist_valid || !dist_stall) begin
      dist_valid <= vld[TOT-1];
    end
  end

  always_ff @(posedge clk) begin
    if ((!dist_valid || !dist_stall) && vld[TOT-1]) begin
      distance_milli_km <= dist_o;
      dot_clamped       <= csh[ACOS_LAT+2];
    end
  end

`ifndef ASSERT_OFF
  // the input side only stalls behind a held result
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    coord_stall |-> (dist_valid && dist_stall && vld[TOT-1]))
    else $error("input stalled without a held result");

  // a frozen last stage keeps its item
  a_last_kept: assert property (@(posedge clk) disable iff (rst)
    (vld[TOT-1] && !en) |=> vld[TOT-1])
    else $error("item lost from the last pipeline stage");

  // a new result only comes from a valid last stage
  a_out_source: assert property (@(posedge clk) disable iff (rst)
    $rose(dist_valid) |-> $past(vld[TOT-1]))
    else $error("result without an item behind it");

  // scaled radius follows the register
  a_radm: assert property (@(posedge clk) disable iff (rst)
    cfg_wr |=> (radm == RADMW'(radius) * RADMW'(1000)))
    else $error("scaled radius out of step with radius register");
`endif

endmodule

FILE: rtl/gcdist_sincos.sv
// angle conversion and cordic rotation pipeline: degrees and minutes to cos and sin
// uses gcdist_pkg; one item per cycle while en is high
module gcdist_sincos (
  input  logic               clk,
  input  logic               en,
  input  logic [7:0]         deg,
  input  logic [12:0]        hmin,
  input  logic               neg,
  output gcdist_pkg::trig_t  cos_v,
  output gcdist_pkg::trig_t  sin_v
);

  localparam int HW   = gcdist_pkg::HW;
  localparam int TW   = gcdist_pkg::TW;
  localparam int BW   = gcdist_pkg::BW;
  localparam int QB   = gcdist_pkg::QB;
  localparam int AW   = gcdist_pkg::AW;
  localparam int ITER = gcdist_pkg::ITER;
  localparam int NW   = gcdist_pkg::NW;
  localparam int PRW  = gcdist_pkg::NW + gcdist_pkg::RCPW;

  localparam gcdist_pkg::angle_t PI_S     = AW'(gcdist_pkg::PI_F);
  localparam gcdist_pkg::angle_t TWO_PI_S = AW'(2 * gcdist_pkg::PI_F);
  localparam gcdist_pkg::angle_t HALF_S   = AW'(gcdist_pkg::HALF_F);
  localparam gcdist_pkg::trig_t  GAIN_S   = gcdist_pkg::CW'(gcdist_pkg::GAIN_F);
  localparam logic [NW-1:0]      ODD_S    = NW'(gcdist_pkg::DIV_ODD);

  logic [HW-1:0] h;
  logic          neg1;

  logic [TW-1:0]  num;
  logic [NW-1:0]  nsh3, nsh4;
  logic [PRW-1:0] rprod;
  logic [QB-1:0]  qe4;
  logic [NW-1:0]  qm4;
  logic [QB-1:0]  quo;
  logic [BW-1:0]  bse [0:3];
  logic           ngs [0:3];

  logic [AW-1:0]      asum;
  gcdist_pkg::angle_t ang;
  gcdist_pkg::angle_t awr;

  gcdist_pkg::trig_t  cx [0:ITER];
  gcdist_pkg::trig_t  cy [0:ITER];
  gcdist_pkg::angle_t cz [0:ITER];
  logic               cf [0:ITER];

  // hundredths of a minute
  always_ff @(posedge clk) begin
    if (en) begin
      h    <= HW'(deg) * HW'(6000) + HW'(hmin);
      neg1 <= neg;
    end
  end

  // angle = h * DIV_Q + round(h * DIV_R / half turn)
  always_ff @(posedge clk) begin
    if (en) begin
      num    <= TW'(h) * TW'(gcdist_pkg::DIV_R) + TW'(gcdist_pkg::HMIN_HALF_TURN >> 1);
      bse[0] <= BW'(h) * BW'(gcdist_pkg::DIV_Q);
      ngs[0] <= neg1;
    end
  end

  // divide by the half turn: drop its power-of-two factor, reciprocal estimate
  // of the odd part (never more than one short), then one correction step
  always_ff @(posedge clk) begin
    if (en) begin
      nsh3   <= num[TW-1:gcdist_pkg::DSH_B];
      rprod  <= PRW'(num[TW-1:gcdist_pkg::DSH_B]) * PRW'(gcdist_pkg::RCP);
      bse[1] <= bse[0];
      ngs[1] <= ngs[0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      nsh4   <= nsh3;
      qe4    <= QB'(rprod >> gcdist_pkg::RCP_SH);
      qm4    <= NW'(QB'(rprod >> gcdist_pkg::RCP_SH)) * ODD_S;
      bse[2] <= bse[1];
      ngs[2] <= ngs[1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      quo    <= ((nsh4 - qm4) >= ODD_S) ? qe4 + QB'(1) : qe4;
      bse[3] <= bse[2];
      ngs[3] <= ngs[2];
    end
  end

  assign asum = AW'(bse[3]) + AW'(quo);

  always_ff @(posedge clk) begin
    if (en) begin
      ang <= ngs[3] ? -$signed(asum) : $signed(asum);
    end
  end

  // wrap by a turn
  always_ff @(posedge clk) begin
    if (en) begin
      if (ang > PI_S) awr <= ang - TWO_PI_S;
      else if (ang < -PI_S) awr <= ang + TWO_PI_S;
      else awr <= ang;
    end
  end

  // fold by a half turn, negate results afterwards
  always_ff @(posedge clk) begin
    if (en) begin
      cx[0] <= GAIN_S;
      cy[0] <= '0;
      if (awr > HALF_S) begin
        cz[0] <= awr - PI_S;
        cf[0] <= 1'b1;
      end else if (awr < -HALF_S) begin
        cz[0] <= awr + PI_S;
        cf[0] <= 1'b1;
      end else begin
        cz[0] <= awr;
        cf[0] <= 1'b0;
      end
    end
  end

  for (genvar i = 0; i < ITER; i++) begin : g_rot
    localparam gcdist_pkg::angle_t ATN = AW'(gcdist_pkg::atn_f(i));
    always_ff @(posedge clk) begin
      if (en) begin
        if (cz[i] >= 0) begin
          cx[i+1] <= cx[i] - (cy[i] >>> i);
          cy[i+1] <= cy[i] + (cx[i] >>> i);
          cz[i+1] <= cz[i] - ATN;
        end else begin
          cx[i+1] <= cx[i] + (cy[i] >>> i);
          cy[i+1] <= cy[i] - (cx[i] >>> i);
          cz[i+1] <= cz[i] + ATN;
        end
        cf[i+1] <= cf[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cos_v <= cf[ITER] ? -cx[ITER] : cx[ITER];
      sin_v <= cf[ITER] ? -cy[ITER] : cy[ITER];
    end
  end

endmodule

FILE: rtl/gcdist_acos.sv
// central angle from the clamped dot product: acos(d) = atan2(sqrt(1 - d*d), d)
// uses gcdist_pkg; digit-serial square root pipeline then cordic vectoring
module gcdist_acos (
  input  logic               clk,
  input  logic               en,
  input  gcdist_pkg::angle_t d,
  output gcdist_pkg::angle_t z
);

  localparam int AW    = gcdist_pkg::AW;
  localparam int RW    = gcdist_pkg::RW;
  localparam int REM_W = gcdist_pkg::REM_W;
  localparam int SQ    = gcdist_pkg::SQRT_STEPS;
  localparam int ITER  = gcdist_pkg::ITER;

  localparam gcdist_pkg::angle_t ONE_S  = AW'(64'd1 << gcdist_pkg::F);
  localparam gcdist_pkg::angle_t HALF_S = AW'(gcdist_pkg::HALF_F);

  logic [2*RW-1:0]    rd [0:SQ];
  logic [REM_W-1:0]   sr [0:SQ];
  logic [RW-1:0]      rt [0:SQ];
  gcdist_pkg::angle_t dd [0:SQ];

  gcdist_pkg::angle_t vx [0:ITER];
  gcdist_pkg::angle_t vy [0:ITER];
  gcdist_pkg::angle_t vz [0:ITER];

  gcdist_pkg::angle_t om, op;

  assign om = ONE_S - d;
  assign op = ONE_S + d;

  // radicand (1 - d)(1 + d)
  always_ff @(posedge clk) begin
    if (en) begin
      rd[0] <= (2*RW)'(om[RW-1:0]) * (2*RW)'(op[RW-1:0]);
      sr[0] <= '0;
      rt[0] <= '0;
      dd[0] <= d;
    end
  end

  // floor square root, one root bit a stage
  for (genvar j = 0; j < SQ; j++) begin : g_sqrt
    logic [REM_W-1:0] trem, trial;
    assign trem  = {sr[j][REM_W-3:0], rd[j][2*RW-1 -: 2]};
    assign trial = REM_W'({rt[j], 2'b01});
    always_ff @(posedge clk) begin
      if (en) begin
        if (trem >= trial) begin
          sr[j+1] <= trem - trial;
          rt[j+1] <= {rt[j][RW-2:0], 1'b1};
        end else begin
          sr[j+1] <= trem;
          rt[j+1] <= {rt[j][RW-2:0], 1'b0};
        end
        rd[j+1] <= rd[j] << 2;
        dd[j+1] <= dd[j];
      end
    end
  end

  // quarter-turn pre-rotation for a negative dot product
  always_ff @(posedge clk) begin
    if (en) begin
      if (dd[SQ] < 0) begin
        vx[0] <= $signed(AW'(rt[SQ]));
        vy[0] <= -dd[SQ];
        vz[0] <= HALF_S;
      end else begin
        vx[0] <= dd[SQ];
        vy[0] <= $signed(AW'(rt[SQ]));
        vz[0] <= '0;
      end
    end
  end

  for (genvar i = 0; i < ITER; i++) begin : g_vec
    localparam gcdist_pkg::angle_t ATN = AW'(gcdist_pkg::atn_f(i));
    always_ff @(posedge clk) begin
      if (en) begin
        if (vy[i] > 0) begin
          vx[i+1] <= vx[i] + (vy[i] >>> i);
          vy[i+1] <= vy[i] - (vx[i] >>> i);
          vz[i+1] <= vz[i] + ATN;
        end else begin
          vx[i+1] <= vx[i] - (vy[i] >>> i);
          vy[i+1] <= vy[i] + (vx[i] >>> i);
          vz[i+1] <= vz[i] - ATN;
        end
      end
    end
  end

  assign z = vz[ITER];

endmodule
